// File: rtl/fwse_pkg.sv
package fwse_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int NUM_WHEELS  = 4;
  localparam int SUM_W       = COUNT_WIDTH + 2;
  localparam int THR_W       = 17;
  localparam int CMP_W       = (SUM_W > THR_W) ? SUM_W : THR_W;
  localparam int CORR_W      = 9;
  localparam int MAG_W       = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_CAP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 2'd3;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [1:0] MODE_LINEAR = 2'd0;
  localparam logic [1:0] MODE_STRAFE = 2'd1;
  localparam logic [1:0] MODE_TURN   = 2'd2;
  localparam logic [1:0] MODE_DIAG   = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_START,
    OP_DONE,
    OP_RUN
  } op_e;

  // per-word control that follows the word down the lane pipeline
  typedef struct packed {
    logic   valid;
    op_e    op;
    logic   diag;
    logic   linear;
    logic   blocked;
    count_t avg;
  } lane_ctrl_t;

  typedef struct packed {
    logic clear;
    logic inc;
  } cnt_ctrl_t;

  typedef struct packed {
    logic [3:0] dir;
    logic       moving;
    logic       done;
    logic       obs;
  } status_t;

endpackage

// File: rtl/fwse_if.sv
interface fwse_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         move_mode;
  logic signed [15:0] target_ticks;
  logic [3:0]         pulse_mask;
  logic [8:0]         front_distance_cm;
  logic [8:0]         rear_distance_cm;

  modport source (
    output valid, kind, move_mode, target_ticks, pulse_mask,
           front_distance_cm, rear_distance_cm,
    input  ready
  );
  modport sink (
    input  valid, kind, move_mode, target_ticks, pulse_mask,
           front_distance_cm, rear_distance_cm,
    output ready
  );
endinterface

interface fwse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_wheel0;
  logic [7:0] pwm_wheel1;
  logic [7:0] pwm_wheel2;
  logic [7:0] pwm_wheel3;
  logic [3:0] direction_bits;
  logic       moving;
  logic       done_res;
  logic       obstacle_stop;

  modport source (
    output valid, pwm_wheel0, pwm_wheel1, pwm_wheel2, pwm_wheel3,
           direction_bits, moving, done_res, obstacle_stop,
    input  ready
  );
  modport sink (
    input  valid, pwm_wheel0, pwm_wheel1, pwm_wheel2, pwm_wheel3,
           direction_bits, moving, done_res, obstacle_stop,
    output ready
  );
endinterface

// File: rtl/fwse_merge.sv
module fwse_merge (
  input  fwse_pkg::count_t                  cnt_i [fwse_pkg::NUM_WHEELS],
  input  logic                              diag_i,
  input  logic [fwse_pkg::MAG_W-1:0]        mag_i,
  output fwse_pkg::count_t                  avg_o,
  output logic                              reached_o
);

  logic [fwse_pkg::SUM_W-1:0] sum01, sum23, sum;
  logic [fwse_pkg::THR_W-1:0] thr;

  always_comb begin
    sum01 = fwse_pkg::SUM_W'(cnt_i[0]) + fwse_pkg::SUM_W'(cnt_i[1]);
    sum23 = fwse_pkg::SUM_W'(cnt_i[2]) + fwse_pkg::SUM_W'(cnt_i[3]);
    sum   = sum01 + sum23;
    // diagonal moves drive two wheels, so the threshold is halved
    thr   = diag_i ? {1'b0, mag_i, 1'b0} : {mag_i, 2'b00};
    reached_o = fwse_pkg::CMP_W'(sum) >= fwse_pkg::CMP_W'(thr);
    avg_o     = sum[fwse_pkg::SUM_W-1:2];
  end

endmodule

// File: rtl/fwse_lane.sv
module fwse_lane (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  fwse_pkg::cnt_ctrl_t   cnt_ctrl_i,
  input  logic                  pulse_i,
  input  fwse_pkg::lane_ctrl_t  s2_i,
  input  fwse_pkg::lane_ctrl_t  s3_i,
  input  logic                  start_off_i,
  input  logic [7:0]            base_i,
  input  logic [7:0]            gain_i,
  input  logic [7:0]            cap_i,
  output fwse_pkg::count_t      cnt_next_o,
  output logic [7:0]            pwm_o
);

  localparam int DIFF_W = fwse_pkg::COUNT_WIDTH + 1;

  fwse_pkg::count_t count_q, count_d;

  logic signed [DIFF_W-1:0]           diff, cap_ext;
  logic signed [fwse_pkg::CORR_W-1:0] corr_d, corr_q;
  logic                               apply_d, apply_q;

  logic signed [17:0] prod;
  logic signed [18:0] num;
  logic [7:0]         sat, hold, pwm_d, pwm_q;

  // stage 1: saturating pulse counter
  always_comb begin
    count_d = count_q;
    if (cnt_ctrl_i.clear) begin
      count_d = '0;
    end else if (cnt_ctrl_i.inc && pulse_i && (count_q != '1)) begin
      count_d = count_q + 1'b1;
    end
  end

  assign cnt_next_o = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // stage 2: error from the average, clamped to the cap
  // count_q still holds this word's count: no new word enters while it waits
  always_comb begin
    diff    = $signed({1'b0, s2_i.avg}) - $signed({1'b0, count_q});
    cap_ext = $signed({{(DIFF_W-8){1'b0}}, cap_i});
    if (diff > cap_ext) begin
      corr_d = fwse_pkg::CORR_W'(cap_ext);
    end else if (diff < -cap_ext) begin
      corr_d = fwse_pkg::CORR_W'(-cap_ext);
    end else begin
      corr_d = fwse_pkg::CORR_W'(diff);
    end
    apply_d = (s2_i.op == fwse_pkg::OP_RUN) && (count_q != '0) &&
              !(s2_i.linear && s2_i.blocked);
  end

  always_ff @(posedge clk_i) begin
    if (en_i && s2_i.valid) begin
      corr_q  <= corr_d;
      apply_q <= apply_d;
    end
  end

  // stage 3: gain, offset and saturation into the pwm register
  always_comb begin
    prod = corr_q * $signed({1'b0, gain_i});
    num  = $signed({7'b0, base_i, 4'b0000}) + 19'(prod);
    if (num[18]) begin
      sat = 8'd0;
    end else if (|num[17:12]) begin
      sat = 8'hFF;
    end else begin
      sat = num[11:4];
    end

    if (s3_i.linear) begin
      hold = s3_i.blocked ? 8'd0 : base_i;
    end else begin
      hold = pwm_q;
    end

    case (s3_i.op)
      fwse_pkg::OP_START: pwm_d = start_off_i ? 8'd0 : base_i;
      fwse_pkg::OP_RUN:   pwm_d = apply_q ? sat : hold;
      default:            pwm_d = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_q <= 8'd0;
    end else if (en_i && s3_i.valid) begin
      pwm_q <= pwm_d;
    end
  end

  assign pwm_o = pwm_q;

endmodule

// File: rtl/four_wheel_speed_equalizer.sv
// Four-wheel distance drive with per-wheel speed equalization.
// in_i takes words of two kinds: a start word (mode and signed target) and a
// tick word (encoder pulse mask and the two ultrasonic readings). Every
// accepted word gives exactly one result word on out_o with the four wheel
// PWM levels, the direction lines and the moving, done and obstacle flags.
// The cfg port writes base speed, gain, error cap and obstacle distance; the
// user must write it only while no word is in flight; nothing enforces it.
// Each word passes three registered stages: pulse counting with the sum and
// target compare, error clamping per wheel, then gain multiply and
// saturation into the PWM register that drives out_o. One word is taken per
// cycle while out_o is not stalled.
// The four wheels run in separate lanes side by side.
// When out_o is stalled the whole pipeline holds and in_i.ready drops in the
// same cycle; it returns as soon as the waiting result is taken.
// Reset clears the counters, PWM levels, move state and flags and loads the
// configuration defaults (128, 16, 10, 40).
module four_wheel_speed_equalizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fwse_in_if.sink                             in_i,
  fwse_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [fwse_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fwse_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic [7:0] base_q, gain_q, cap_q;
  logic [8:0] limit_q;

  logic [1:0]                 mode_q, mode_d;
  logic [fwse_pkg::MAG_W-1:0] mag_q, mag_d;
  logic                       neg_q, neg_d;
  logic                       active_q, active_d;
  logic                       flag_q, flag_d;
  logic [3:0]                 dir_q, dir_d;

  logic en, acc;
  logic [15:0] abs_t;
  logic [fwse_pkg::MAG_W-1:0] mag_new;
  logic t_neg, t_pos;
  logic [3:0] pat;
  logic [8:0] sensor_cm;
  logic blocked;

  fwse_pkg::cnt_ctrl_t  cnt_ctrl;
  fwse_pkg::lane_ctrl_t s1_ctrl, s2_q, s3_q;
  fwse_pkg::status_t    s1_st, st2_q, st3_q, st_out_q;
  logic                 out_valid_q;

  fwse_pkg::count_t cnt_next [fwse_pkg::NUM_WHEELS];
  fwse_pkg::count_t avg;
  logic             reached;
  logic [7:0]       pwm [fwse_pkg::NUM_WHEELS];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 8'd128;
      gain_q  <= 8'd16;
      cap_q   <= 8'd10;
      limit_q <= 9'd40;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fwse_pkg::CFG_BASE_SPEED: base_q  <= cfg_wdata_i[7:0];
        fwse_pkg::CFG_GAIN:       gain_q  <= cfg_wdata_i[7:0];
        fwse_pkg::CFG_DELTA_CAP:  cap_q   <= cfg_wdata_i[7:0];
        fwse_pkg::CFG_DIST_LIMIT: limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign acc        = in_i.valid && en;

  // start decode
  always_comb begin
    t_neg   = in_i.target_ticks[15];
    t_pos   = !t_neg && (in_i.target_ticks != 16'sd0);
    abs_t   = t_neg ? 16'(-in_i.target_ticks) : in_i.target_ticks;
    // only the most negative target leaves bit 15 set
    mag_new = abs_t[15] ? '1 : abs_t[14:0];
    case (in_i.move_mode)
      fwse_pkg::MODE_LINEAR: pat = t_pos ? 4'hC : 4'h3;
      fwse_pkg::MODE_TURN:   pat = t_neg ? 4'h9 : 4'h6;
      fwse_pkg::MODE_STRAFE: pat = t_pos ? 4'hA : 4'h5;
      default:               pat = t_pos ? 4'hA : 4'h5;
    endcase
  end

  assign cnt_ctrl.clear = acc && (in_i.kind == fwse_pkg::KIND_START);
  assign cnt_ctrl.inc   = acc && (in_i.kind == fwse_pkg::KIND_TICK) && active_q;

  fwse_merge u_merge (
    .cnt_i     (cnt_next),
    .diag_i    (mode_q == fwse_pkg::MODE_DIAG),
    .mag_i     (mag_q),
    .avg_o     (avg),
    .reached_o (reached)
  );

  assign sensor_cm = neg_q ? in_i.rear_distance_cm : in_i.front_distance_cm;
  assign blocked   = (sensor_cm != 9'd0) && (sensor_cm <= limit_q);

  // stage 1: move state and per-word control
  always_comb begin
    mode_d   = mode_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    active_d = active_q;
    flag_d   = flag_q;
    dir_d    = dir_q;

    s1_ctrl         = '0;
    s1_ctrl.valid   = acc;
    s1_ctrl.op      = fwse_pkg::OP_IDLE;
    s1_ctrl.diag    = mode_q == fwse_pkg::MODE_DIAG;
    s1_ctrl.avg     = avg;

    s1_st.moving = 1'b0;
    s1_st.done   = 1'b0;
    s1_st.obs    = flag_q;

    if (in_i.kind == fwse_pkg::KIND_START) begin
      mode_d   = in_i.move_mode;
      mag_d    = mag_new;
      neg_d    = t_neg;
      flag_d   = 1'b0;
      dir_d    = pat;
      active_d = mag_new != '0;
      s1_ctrl.diag = in_i.move_mode == fwse_pkg::MODE_DIAG;
      s1_ctrl.op   = active_d ? fwse_pkg::OP_START : fwse_pkg::OP_DONE;
      s1_st.moving = active_d;
      s1_st.done   = !active_d;
      s1_st.obs    = 1'b0;
    end else if (active_q) begin
      if (reached) begin
        active_d   = 1'b0;
        s1_ctrl.op = fwse_pkg::OP_DONE;
        s1_st.done = 1'b1;
      end else begin
        s1_ctrl.op   = fwse_pkg::OP_RUN;
        s1_st.moving = 1'b1;
        if (mode_q == fwse_pkg::MODE_LINEAR) begin
          s1_ctrl.linear  = 1'b1;
          s1_ctrl.blocked = blocked;
          flag_d          = blocked;
          s1_st.obs       = blocked;
        end
      end
    end
    s1_st.dir = dir_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= '0;
      mag_q    <= '0;
      neg_q    <= 1'b0;
      active_q <= 1'b0;
      flag_q   <= 1'b0;
      dir_q    <= '0;
    end else if (acc) begin
      mode_q   <= mode_d;
      mag_q    <= mag_d;
      neg_q    <= neg_d;
      active_q <= active_d;
      flag_q   <= flag_d;
      dir_q    <= dir_d;
    end
  end

  // pipeline registers, all held while the output word waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q        <= '0;
      s3_q        <= '0;
      st2_q       <= '0;
      st3_q       <= '0;
      st_out_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s2_q        <= s1_ctrl;
      st2_q       <= s1_st;
      s3_q        <= s2_q;
      st3_q       <= st2_q;
      st_out_q    <= st3_q;
      out_valid_q <= s3_q.valid;
    end
  end

  for (genvar w = 0; w < fwse_pkg::NUM_WHEELS; w++) begin : g_lane
    fwse_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .cnt_ctrl_i  (cnt_ctrl),
      .pulse_i     (in_i.pulse_mask[w]),
      .s2_i        (s2_q),
      .s3_i        (s3_q),
      // diagonal moves start with the middle wheels off
      .start_off_i (s3_q.diag && ((w == 1) || (w == 2))),
      .base_i      (base_q),
      .gain_i      (gain_q),
      .cap_i       (cap_q),
      .cnt_next_o  (cnt_next[w]),
      .pwm_o       (pwm[w])
    );
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pwm_wheel0     = pwm[0];
  assign out_o.pwm_wheel1     = pwm[1];
  assign out_o.pwm_wheel2     = pwm[2];
  assign out_o.pwm_wheel3     = pwm[3];
  assign out_o.direction_bits = st_out_q.dir;
  assign out_o.moving         = st_out_q.moving;
  assign out_o.done_res       = st_out_q.done;
  assign out_o.obstacle_stop  = st_out_q.obs;

endmodule
